// ===== design/brb_pkg.sv =====
`timescale 1ns / 1ps

package brb_pkg;

   localparam int DEFAULT_DEPTH = 4096;
   localparam int FIELD_W       = 13;

   typedef enum logic [2:0] {
      OP_OPEN  = 3'd0,
      OP_WRITE = 3'd1,
      OP_POP   = 3'd2,
      OP_PEEK  = 3'd3,
      OP_RAW   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_SHORT = 2'd2,
      ST_DROP  = 2'd3
   } status_type;

   // Travels with a transaction from acceptance to its result cycle.
   typedef struct packed {
      logic       valid;
      status_type status;
      logic       rd_en;
   } rsp_info_type;

endpackage

// ===== design/byte_ring_buffer.sv =====
`timescale 1ns / 1ps

// Circular byte store of DEPTH entries. Every transaction gives exactly one
// result, on the rsp_ ports in the cycle after the transaction is
// accepted, marked by rsp_valid; the receiver must take it in that cycle.
// Each transaction costs at most one access to the single-port byte memory,
// whose registered read output sets that result delay. busy never rises, so a new
// transaction can be started in every cycle, one per cycle sustained. The
// memory is not cleared after reset: a raw read of an entry that was never
// written returns an arbitrary byte. Counts on the result are those after
// the transaction.
module byte_ring_buffer import brb_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [7:0]         req_data_byte,
   input  logic [FIELD_W-1:0] req_count,
   input  logic [FIELD_W-1:0] req_position,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_read_data,
   output logic [FIELD_W-1:0] rsp_fill_count,
   output logic [FIELD_W-1:0] rsp_free_count
);

   localparam int PTR_W = $clog2(DEPTH);

   logic             accept;
   logic             mem_we;
   logic             mem_re;
   logic [PTR_W-1:0] mem_addr;
   logic [7:0]       mem_wdata;
   logic [7:0]       mem_rdata;
   rsp_info_type     info;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   brb_ctrl #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_operation),
      .data_byte  (req_data_byte),
      .count      (req_count),
      .position   (req_position),
      .mem_we     (mem_we),
      .mem_re     (mem_re),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .info       (info),
      .fill_count (rsp_fill_count),
      .free_count (rsp_free_count)
   );

   brb_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (PTR_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_valid     = info.valid;
   assign rsp_status    = info.status;
   assign rsp_read_data = info.rd_en ? mem_rdata : 8'd0;

endmodule

// ===== design/brb_mem.sv =====
`timescale 1ns / 1ps

module brb_mem import brb_pkg::*; #(
   parameter int DEPTH  = DEFAULT_DEPTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wdata,
   output logic [7:0]        rdata
);

   logic [7:0] store [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/brb_ctrl.sv =====
`timescale 1ns / 1ps

module brb_ctrl import brb_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [2:0]         operation,
   input  logic [7:0]         data_byte,
   input  logic [FIELD_W-1:0] count,
   input  logic [FIELD_W-1:0] position,
   output logic               mem_we,
   output logic               mem_re,
   output logic [PTR_W-1:0]   mem_addr,
   output logic [7:0]         mem_wdata,
   output rsp_info_type       info,
   output logic [FIELD_W-1:0] fill_count,
   output logic [FIELD_W-1:0] free_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
   localparam int SUM_W = CNT_W + 1;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0] pend_ff, pend_in;
   rsp_info_type     info_ff, info_in;

   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] pos_ext;
   logic [CNT_W-1:0] cnt_n;
   logic [PTR_W-1:0] pos_n;
   logic [SUM_W-1:0] head_sum;
   logic [SUM_W-1:0] peek_sum;
   logic [PTR_W-1:0] head_adv;
   logic [PTR_W-1:0] peek_addr;
   logic [PTR_W-1:0] tail_adv;
   status_type       status_v;
   logic             rd_en_v;

   assign cnt_ext = CMP_W'(count);
   assign pos_ext = CMP_W'(position);
   // Both are only used once they are known to be in range.
   assign cnt_n   = cnt_ext[CNT_W-1:0];
   assign pos_n   = pos_ext[PTR_W-1:0];

   // Ring additions: both operands stay below twice the depth, so one
   // compare and subtract wraps them.
   assign head_sum  = SUM_W'(head_ff) + SUM_W'(cnt_n);
   assign peek_sum  = SUM_W'(head_ff) + SUM_W'(pos_n);
   assign head_adv  = (head_sum >= SUM_W'(DEPTH)) ?
                      PTR_W'(head_sum - SUM_W'(DEPTH)) : PTR_W'(head_sum);
   assign peek_addr = (peek_sum >= SUM_W'(DEPTH)) ?
                      PTR_W'(peek_sum - SUM_W'(DEPTH)) : PTR_W'(peek_sum);
   assign tail_adv  = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      held_in   = held_ff;
      free_in   = free_ff;
      pend_in   = pend_ff;
      status_v  = ST_OK;
      rd_en_v   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = tail_ff;
      mem_wdata = data_byte;
      if (accept) begin
         unique case (op_type'(operation))
            OP_OPEN: begin
               if (cnt_ext > CMP_W'(DEPTH)) begin
                  status_v = ST_RANGE;
               end else if (cnt_ext > CMP_W'(free_ff)) begin
                  status_v = ST_SHORT;
               end else begin
                  free_in = free_ff - cnt_n;
                  pend_in = pend_ff + cnt_n;
               end
            end
            OP_WRITE: begin
               if (pend_ff == '0) begin
                  status_v = ST_DROP;
               end else begin
                  mem_we  = 1'b1;
                  tail_in = tail_adv;
                  pend_in = pend_ff - 1'b1;
                  held_in = held_ff + 1'b1;
               end
            end
            OP_POP: begin
               if (cnt_ext > CMP_W'(DEPTH)) begin
                  status_v = ST_RANGE;
               end else if (cnt_ext > CMP_W'(held_ff)) begin
                  status_v = ST_SHORT;
               end else begin
                  head_in = head_adv;
                  held_in = held_ff - cnt_n;
                  free_in = free_ff + cnt_n;
               end
            end
            OP_PEEK: begin
               if (pos_ext >= CMP_W'(DEPTH)) begin
                  status_v = ST_RANGE;
               end else if (pos_ext >= CMP_W'(held_ff)) begin
                  status_v = ST_SHORT;
               end else begin
                  mem_re   = 1'b1;
                  mem_addr = peek_addr;
                  rd_en_v  = 1'b1;
               end
            end
            OP_RAW: begin
               if (pos_ext >= CMP_W'(DEPTH)) begin
                  status_v = ST_RANGE;
               end else begin
                  mem_re   = 1'b1;
                  mem_addr = pos_n;
                  rd_en_v  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      info_in = '{valid: accept, status: status_v, rd_en: rd_en_v};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         held_ff <= '0;
         free_ff <= CNT_W'(DEPTH);
         pend_ff <= '0;
         info_ff <= '{valid: 1'b0, status: ST_OK, rd_en: 1'b0};
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         held_ff <= held_in;
         free_ff <= free_in;
         pend_ff <= pend_in;
         info_ff <= info_in;
      end
   end

   assign info       = info_ff;
   assign fill_count = FIELD_W'(held_ff);
   assign free_count = FIELD_W'(free_ff);

   // Every byte of the ring is held, free or reserved, never two of these.
   a_conserved: assert property (@(posedge clock) disable iff (reset)
      (SUM_W + 1)'(held_ff) + (SUM_W + 1)'(free_ff) + (SUM_W + 1)'(pend_ff)
         == (SUM_W + 1)'(DEPTH))
      else $error("held, free and reserved counts do not add up to the depth");

   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("memory written and read in the same cycle");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> info_ff.valid)
      else $error("accepted transaction produced no result");

   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      info_ff.rd_en |-> info_ff.valid && info_ff.status == ST_OK)
      else $error("read data selected for a failed or missing transaction");

   a_tail_moves: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> held_ff == $past(held_ff) + 1'b1)
      else $error("stored byte not counted as held");

endmodule

// ===== sim/byte_ring_checker.sv =====
`timescale 1ns / 1ps

module byte_ring_checker import brb_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [7:0]         req_data_byte,
   input  logic [FIELD_W-1:0] req_count,
   input  logic [FIELD_W-1:0] req_position,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_status,
   input  logic [7:0]         rsp_read_data,
   input  logic [FIELD_W-1:0] rsp_fill_count,
   input  logic [FIELD_W-1:0] rsp_free_count,
   output int                 fail_count,
   output int                 outstanding,
   output int unsigned        held_now,
   output int unsigned        free_now,
   output int unsigned        reserved_now,
   output logic [DEPTH-1:0]   written_map
);

   typedef struct {
      status_type         status;
      logic [7:0]         read_data;
      logic [FIELD_W-1:0] fill_bytes;
      logic [FIELD_W-1:0] free_bytes;
   } answer_type;

   logic [7:0]  ring_mem [DEPTH];
   int unsigned head_idx;
   int unsigned tail_idx;
   answer_type  answer_q [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   task automatic report_error(input string what);
      $display("%0t: mismatch, %s", $time, what);
      fail_count++;
   endtask

   // Applies one transaction to the mirrored ring and works out its result.
   task automatic apply_command(input logic [2:0] op, input logic [7:0] din,
                                input logic [FIELD_W-1:0] cnt,
                                input logic [FIELD_W-1:0] pos,
                                output answer_type ans);
      ans.status    = ST_OK;
      ans.read_data = '0;
      case (op)
         OP_OPEN: begin
            if (cnt > DEPTH) ans.status = ST_RANGE;
            else if (cnt > free_now) ans.status = ST_SHORT;
            else begin
               free_now     = free_now - cnt;
               reserved_now = reserved_now + cnt;
            end
         end
         OP_WRITE: begin
            if (reserved_now == 0) ans.status = ST_DROP;
            else begin
               ring_mem[tail_idx]    = din;
               written_map[tail_idx] = 1'b1;
               tail_idx              = (tail_idx + 1) % DEPTH;
               reserved_now          = reserved_now - 1;
               held_now              = held_now + 1;
            end
         end
         OP_POP: begin
            if (cnt > DEPTH) ans.status = ST_RANGE;
            else if (cnt > held_now) ans.status = ST_SHORT;
            else begin
               head_idx = (head_idx + cnt) % DEPTH;
               held_now = held_now - cnt;
               free_now = free_now + cnt;
            end
         end
         OP_PEEK: begin
            if (pos >= DEPTH) ans.status = ST_RANGE;
            else if (pos >= held_now) ans.status = ST_SHORT;
            else ans.read_data = ring_mem[(head_idx + pos) % DEPTH];
         end
         OP_RAW: begin
            if (pos >= DEPTH) ans.status = ST_RANGE;
            else ans.read_data = ring_mem[pos];
         end
         default: ;
      endcase
      ans.fill_bytes = held_now[FIELD_W-1:0];
      ans.free_bytes = free_now[FIELD_W-1:0];
   endtask

   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         head_idx     = 0;
         tail_idx     = 0;
         held_now     = 0;
         free_now     = DEPTH;
         reserved_now = 0;
         written_map  = '0;
         answer_q.delete();
      end else begin
         // The result of a transaction shows up in the cycle after it, so the
         // older expectation is retired before the new one is queued.
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               report_error("result with no transaction waiting");
            end else begin
               want = answer_q.pop_front();
               if (rsp_status !== want.status)
                  report_error($sformatf("status %0d, expected %s",
                                         rsp_status, want.status.name()));
               if (rsp_read_data !== want.read_data)
                  report_error($sformatf("read_data %0d, expected %0d",
                                         rsp_read_data, want.read_data));
               if (rsp_fill_count !== want.fill_bytes)
                  report_error($sformatf("fill_count %0d, expected %0d",
                                         rsp_fill_count, want.fill_bytes));
               if (rsp_free_count !== want.free_bytes)
                  report_error($sformatf("free_count %0d, expected %0d",
                                         rsp_free_count, want.free_bytes));
            end
         end
         if (start && !busy) begin
            apply_command(req_operation, req_data_byte, req_count, req_position, want);
            answer_q.push_back(want);
         end
      end
      outstanding = answer_q.size();
   end

endmodule

// ===== sim/byte_ring_buffer_test.sv =====
`timescale 1ns / 1ps

module byte_ring_buffer_test;
   import brb_pkg::*;

   localparam int DEPTH      = DEFAULT_DEPTH;
   localparam int MAX_FIELD  = (1 << FIELD_W) - 1;
   localparam int ITEMS      = 1500;
   localparam int IDLE_LIMIT = 500;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_operation;
   logic [7:0]         req_data_byte;
   logic [FIELD_W-1:0] req_count;
   logic [FIELD_W-1:0] req_position;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_read_data;
   logic [FIELD_W-1:0] rsp_fill_count;
   logic [FIELD_W-1:0] rsp_free_count;

   int                 fail_count;
   int                 outstanding;
   int unsigned        held_now;
   int unsigned        free_now;
   int unsigned        reserved_now;
   logic [DEPTH-1:0]   written_map;

   int                 idle_cycles = 0;
   int                 issued;
   int                 quiet_left;
   bit                 held_off;

   byte_ring_buffer #(.DEPTH(DEPTH)) DUT (.*);

   byte_ring_checker #(.DEPTH(DEPTH)) ring_check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   function automatic logic [FIELD_W-1:0] any_field();
      logic [FIELD_W-1:0] v;
      v = FIELD_W'($urandom);
      return v;
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [FIELD_W-1:0] field_of(input int unsigned v);
      return FIELD_W'(v);
   endfunction

   // Raw reads must only hit entries that have been written at least once.
   function automatic logic [FIELD_W-1:0] pick_raw_index();
      int idx;
      for (int tries = 0; tries < 8; tries++) begin
         idx = $urandom_range(0, DEPTH - 1);
         if (written_map[idx]) return idx[FIELD_W-1:0];
      end
      return field_of($urandom_range(DEPTH, MAX_FIELD));
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send(input logic [2:0] op, input logic [7:0] din,
                       input logic [FIELD_W-1:0] cnt, input logic [FIELD_W-1:0] pos);
      int gap;
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 79) == 0) quiet_left = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_data_byte <= din;
      req_count     <= cnt;
      req_position  <= pos;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      issued++;
   endtask

   task automatic send_read();
      logic [FIELD_W-1:0] pos;
      if ($urandom_range(0, 1) == 0) begin
         if (held_now > 0 && $urandom_range(0, 7) != 0)
            pos = field_of($urandom_range(0, held_now - 1));
         else pos = any_field();
         send(OP_PEEK, any_byte(), any_field(), pos);
      end else begin
         if ($urandom_range(0, 9) == 0) pos = field_of($urandom_range(DEPTH, MAX_FIELD));
         else pos = pick_raw_index();
         send(OP_RAW, any_byte(), any_field(), pos);
      end
   endtask

   task automatic send_pop();
      logic [FIELD_W-1:0] amount;
      if ($urandom_range(0, 7) == 0)
         amount = field_of($urandom_range(held_now + 1, MAX_FIELD));
      else amount = field_of($urandom_range(0, held_now));
      send(OP_POP, any_byte(), amount, any_field());
   endtask

   // Opens a block and fills it, with reads, pops and further opens mixed in.
   task automatic send_block();
      int unsigned size;
      if (free_now == 0) size = 1;
      else if ($urandom_range(0, 9) == 0)
         size = $urandom_range(1, (free_now < 300) ? free_now : 300);
      else size = $urandom_range(1, (free_now < 16) ? free_now : 16);
      send(OP_OPEN, any_byte(), field_of(size), any_field());
      while (reserved_now > 0) begin
         case ($urandom_range(0, 9))
            0: send_read();
            1: send_pop();
            2: send(OP_OPEN, any_byte(), field_of($urandom_range(0, 4)), any_field());
            default: ;
         endcase
         send(OP_WRITE, any_byte(), any_field(), any_field());
      end
   endtask

   task automatic send_noise();
      logic [2:0]         op;
      logic [FIELD_W-1:0] cnt;
      logic [FIELD_W-1:0] pos;
      op  = 3'($urandom_range(0, 7));
      cnt = any_field();
      pos = any_field();
      // A random open that succeeds could reserve thousands of bytes.
      if (op == OP_OPEN) cnt = field_of($urandom_range(free_now + 1, MAX_FIELD));
      if (op == OP_RAW && pos < DEPTH) pos = pick_raw_index();
      send(op, any_byte(), cnt, pos);
   endtask

   initial begin
      int pick;
      start         = 1'b0;
      req_operation = '0;
      req_data_byte = '0;
      req_count     = '0;
      req_position  = '0;
      reset         = 1'b1;
      issued        = 0;
      quiet_left    = 0;
      held_off      = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Edge cases on an empty ring.
      send(OP_WRITE, 8'hFF, any_field(), any_field());
      send(OP_OPEN, 8'h00, field_of(0), any_field());
      send(OP_POP, 8'h00, field_of(0), any_field());
      send(OP_PEEK, 8'h00, any_field(), field_of(0));
      send(OP_PEEK, 8'h00, any_field(), field_of(DEPTH));
      send(OP_RAW, 8'h00, any_field(), field_of(MAX_FIELD));
      send(OP_RAW, 8'h00, any_field(), field_of(DEPTH));
      send(OP_POP, 8'h00, field_of(DEPTH + 1), any_field());
      send(OP_POP, 8'h00, field_of(1), any_field());
      send(OP_OPEN, 8'h00, field_of(MAX_FIELD), any_field());
      send(OP_OPEN, 8'h00, field_of(DEPTH + 1), any_field());
      for (int code = int'(OP_RAW) + 1; code < 8; code++)
         send(code[2:0], any_byte(), any_field(), any_field());

      // Reserve the whole ring, then fill it completely.
      send(OP_OPEN, 8'h00, field_of(DEPTH), any_field());
      send(OP_OPEN, 8'h00, field_of(1), any_field());
      send(OP_OPEN, 8'h00, field_of(0), any_field());
      send(OP_WRITE, 8'h00, any_field(), any_field());
      send(OP_WRITE, 8'hFF, any_field(), any_field());
      while (reserved_now > 0) send(OP_WRITE, any_byte(), any_field(), any_field());
      send(OP_WRITE, 8'hA5, any_field(), any_field());
      send(OP_PEEK, 8'h00, any_field(), field_of(DEPTH - 1));
      send(OP_PEEK, 8'h00, any_field(), field_of(0));
      send(OP_RAW, 8'h00, any_field(), field_of(0));
      send(OP_RAW, 8'h00, any_field(), field_of(DEPTH - 1));
      send(OP_POP, 8'h00, field_of(DEPTH), any_field());
      send(OP_OPEN, 8'h00, field_of(3), any_field());
      send(OP_OPEN, 8'h00, field_of(2), any_field());
      while (reserved_now > 0) send(OP_WRITE, any_byte(), any_field(), any_field());
      send(OP_PEEK, 8'h00, any_field(), field_of(4));
      send(OP_POP, 8'h00, field_of(2), any_field());

      issued = 0;
      while (issued < ITEMS) begin
         if (!held_off && issued >= ITEMS / 2) begin
            start <= 1'b0;
            @(negedge clock);
            while (outstanding != 0) @(negedge clock);
            held_off = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) send_block();
         else if (pick < 60) send_pop();
         else if (pick < 80) send_read();
         else send_noise();
      end

      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
